// ----- hw/rtl/i2cms_pkg.sv -----
package i2cms_pkg;

  // request codes carried in s_tuser
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_WAIT  = 3'd4;

  // acknowledge choice after a read
  localparam logic [1:0] ACK_SEND = 2'd1;
  localparam logic [1:0] ACK_NACK = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  // configuration reset values
  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // packed stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  // active command, one-hot
  typedef enum logic [5:0] {
    CMD_IDLE  = 6'b000001,
    CMD_START = 6'b000010,
    CMD_STOP  = 6'b000100,
    CMD_WRITE = 6'b001000,
    CMD_READ  = 6'b010000,
    CMD_WAIT  = 6'b100000
  } cmd_t;

  // map a request code to its command state
  function automatic cmd_t req_to_cmd(input logic [2:0] req);
    cmd_t c;
    case (req)
      REQ_START: c = CMD_START;
      REQ_STOP:  c = CMD_STOP;
      REQ_WRITE: c = CMD_WRITE;
      REQ_READ:  c = CMD_READ;
      REQ_WAIT:  c = CMD_WAIT;
      default:   c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/i2c_master_bit_sequencer_core.sv -----
// I2C master bit sequencer. Each request on the s_ side is one tick of the
// bus sequencer; it may carry a command (start, stop, write byte, read byte
// with optional ACK/NACK, wait for acknowledge) plus the sampled SDA level.
// Commands are taken only while ready_res is high; otherwise the command
// bits are ignored but the tick still advances the sequencer.
// Each request yields exactly one result on the m_ side: SCL level, SDA
// release, ready, done pulse, last read byte and the missing-ack flag, all
// as they stand after that tick.
// The tick logic sits between the input and an output register backed by
// a one-entry skid buffer; one request is taken every cycle while the skid
// buffer is empty.
// When the receiver stalls, one more request is absorbed into the skid
// buffer, then s_tready drops until the output drains.
// The cfg channel writes phase_ticks (index 0) and ack_timeout_ticks
// (index 1); it is always ready. Reset restores 5 and 250, idles the
// sequencer with SCL and SDA released, and empties the output side.
module i2c_master_bit_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: cmd_valid[0], tx_byte[8:1], ack_mode[10:9], sda_in[11], zeros
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [i2cms_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: req_type[2:0]
  input  logic [i2cms_pkg::IN_USER_W-1:0]    s_tuser,
  // m_tdata: scl_level[0], sda_release[1], ready_res[2], done_res[3],
  //          rx_byte[11:4], ack_missing[12], zeros
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [i2cms_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                         cfg_data
);
  import i2cms_pkg::*;

  // unpacked request fields
  logic       cmd_valid;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic [1:0] ack_mode;
  logic       sda_in;

  assign cmd_valid = s_tdata[0];
  assign tx_byte   = s_tdata[8:1];
  assign ack_mode  = s_tdata[10:9];
  assign sda_in    = s_tdata[11];
  assign req_type  = s_tuser;

  // configuration
  logic [7:0] phase_ticks;
  logic [7:0] ack_timeout_ticks;

  // sequencer state
  cmd_t       cmd, cmd_next;
  logic [2:0] phase_step, phase_step_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] tick_div, tick_div_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] timeout_count, timeout_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic [1:0] ack_choice, ack_choice_next;
  logic       missing_flag, missing_flag_next;
  logic [7:0] rx_hold, rx_hold_next;

  // tick scratch
  logic       done_now;
  logic       enter;
  logic [2:0] enter_step;
  logic       fin;
  logic       fin_scl_low;
  logic [7:0] pt;
  logic [7:0] lim;
  logic [7:0] tcnt;
  logic [3:0] bitc;

  // output register and skid stage
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [OUT_DATA_W-1:0] result;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;

  assign pt  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign lim = (ack_timeout_ticks == 8'd0) ? 8'd1 : ack_timeout_ticks;

  // one sequencer tick
  always_comb begin
    cmd_next           = cmd;
    phase_step_next    = phase_step;
    bit_count_next     = bit_count;
    tick_div_next      = tick_div;
    shift_reg_next     = shift_reg;
    timeout_count_next = timeout_count;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    ack_choice_next    = ack_choice;
    missing_flag_next  = missing_flag;
    rx_hold_next       = rx_hold;
    done_now           = 1'b0;
    enter              = 1'b0;
    enter_step         = 3'd0;
    fin                = 1'b0;
    fin_scl_low        = 1'b0;
    tcnt               = timeout_count;
    bitc               = bit_count + 4'd1;

    if (cmd == CMD_IDLE) begin
      // command launch
      if (cmd_valid && req_type <= REQ_WAIT) begin
        cmd_next           = req_to_cmd(req_type);
        bit_count_next     = 4'd0;
        timeout_count_next = 8'd0;
        if (req_type == REQ_WRITE) shift_reg_next = tx_byte;
        if (req_type == REQ_READ) begin
          shift_reg_next  = 8'd0;
          ack_choice_next = ack_mode;
        end
        if (req_type == REQ_WAIT) missing_flag_next = 1'b0;
        enter = 1'b1;
      end
    end else if (cmd == CMD_WAIT && phase_step == 3'd2) begin
      // acknowledge polling
      if (!sda_in) begin
        enter      = 1'b1;
        enter_step = 3'd3;
      end else begin
        if (timeout_count != 8'hFF) tcnt = timeout_count + 8'd1;
        timeout_count_next = tcnt;
        if (tcnt >= lim) begin
          missing_flag_next = 1'b1;
          cmd_next          = CMD_STOP;
          enter             = 1'b1;
        end
      end
    end else begin
      // sample read bit on the first tick with SCL high
      if (cmd == CMD_READ && phase_step == 3'd1 && tick_div == 8'd1)
        shift_reg_next = {shift_reg[6:0], sda_in};
      if (tick_div >= pt) begin
        case (cmd)
          CMD_START: begin
            if (phase_step == 3'd0) begin
              enter      = 1'b1;
              enter_step = 3'd1;
            end else begin
              fin         = 1'b1;
              fin_scl_low = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_step < 3'd2) begin
              enter      = 1'b1;
              enter_step = phase_step + 3'd1;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_step < 3'd2) begin
              enter      = 1'b1;
              enter_step = phase_step + 3'd1;
            end else begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_count_next = bitc;
              if (bitc >= BYTE_BITS) fin = 1'b1;
              else enter = 1'b1;
            end
          end
          CMD_READ: begin
            if (phase_step == 3'd0) begin
              enter      = 1'b1;
              enter_step = 3'd1;
            end else if (phase_step == 3'd1) begin
              bit_count_next = bitc;
              if (bitc < BYTE_BITS) begin
                enter = 1'b1;
              end else begin
                rx_hold_next = shift_reg_next;
                if (ack_choice == ACK_SEND || ack_choice == ACK_NACK) begin
                  enter      = 1'b1;
                  enter_step = 3'd3;
                end else begin
                  fin = 1'b1;
                end
              end
            end else if (phase_step == 3'd3) begin
              enter      = 1'b1;
              enter_step = 3'd4;
            end else begin
              fin         = 1'b1;
              fin_scl_low = 1'b1;
            end
          end
          CMD_WAIT: begin
            if (phase_step == 3'd0) begin
              enter      = 1'b1;
              enter_step = 3'd1;
            end else if (phase_step == 3'd1) begin
              phase_step_next = 3'd2;
              tick_div_next   = 8'd0;
            end else begin
              fin         = 1'b1;
              fin_scl_low = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        tick_div_next = tick_div + 8'd1;
      end
    end

    // command end
    if (fin) begin
      if (fin_scl_low) scl_reg_next = 1'b0;
      cmd_next        = CMD_IDLE;
      phase_step_next = 3'd0;
      tick_div_next   = 8'd0;
      done_now        = 1'b1;
    end

    // pin levels of the phase just entered
    if (enter) begin
      phase_step_next = enter_step;
      tick_div_next   = 8'd1;
      case (cmd_next)
        CMD_START: begin
          if (enter_step == 3'd0) begin
            scl_reg_next = 1'b1;
            sda_reg_next = 1'b1;
          end else begin
            sda_reg_next = 1'b0;
          end
        end
        CMD_STOP: begin
          if (enter_step == 3'd0) begin
            scl_reg_next = 1'b0;
            sda_reg_next = 1'b0;
          end else if (enter_step == 3'd1) begin
            scl_reg_next = 1'b1;
          end else begin
            sda_reg_next = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (enter_step == 3'd0) begin
            scl_reg_next = 1'b0;
            sda_reg_next = shift_reg_next[7];
          end else if (enter_step == 3'd1) begin
            scl_reg_next = 1'b1;
          end else begin
            scl_reg_next = 1'b0;
          end
        end
        CMD_READ: begin
          if (enter_step == 3'd0) begin
            scl_reg_next = 1'b0;
            sda_reg_next = 1'b1;
          end else if (enter_step == 3'd3) begin
            scl_reg_next = 1'b0;
            sda_reg_next = (ack_choice_next == ACK_SEND) ? 1'b0 : 1'b1;
          end else begin
            scl_reg_next = 1'b1;
          end
        end
        default: begin
          if (enter_step == 3'd0) sda_reg_next = 1'b1;
          else if (enter_step == 3'd1) scl_reg_next = 1'b1;
          else if (enter_step == 3'd3) scl_reg_next = 1'b0;
        end
      endcase
    end

    result = {3'b000, missing_flag_next, rx_hold_next, done_now,
              (cmd_next == CMD_IDLE), sda_reg_next, scl_reg_next};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= PHASE_TICKS_RST;
      ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PHASE_TICKS) phase_ticks <= cfg_data;
      if (cfg_index == CFG_ACK_TIMEOUT) ack_timeout_ticks <= cfg_data;
    end
  end

  // sequencer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd           <= CMD_IDLE;
      phase_step    <= 3'd0;
      bit_count     <= 4'd0;
      tick_div      <= 8'd0;
      shift_reg     <= 8'd0;
      timeout_count <= 8'd0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      ack_choice    <= 2'd0;
      missing_flag  <= 1'b0;
      rx_hold       <= 8'd0;
    end else if (accept) begin
      cmd           <= cmd_next;
      phase_step    <= phase_step_next;
      bit_count     <= bit_count_next;
      tick_div      <= tick_div_next;
      shift_reg     <= shift_reg_next;
      timeout_count <= timeout_count_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      ack_choice    <= ack_choice_next;
      missing_flag  <= missing_flag_next;
      rx_hold       <= rx_hold_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!m_tvalid || m_tready) begin
        m_tdata  <= result;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
